// File: rtl/core/ga_bitwise_crossover_mutation_top_macros.svh
// Assertion macros shared by the genetic-operator block
`ifndef GA_BITWISE_CROSSOVER_MUTATION_TOP_MACROS_SVH
`define GA_BITWISE_CROSSOVER_MUTATION_TOP_MACROS_SVH

// Clocked check, switched off while reset is high
`define GABCM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Clocked check that also holds through reset
`define GABCM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// File: rtl/core/gabcm_pkg.sv
// Shared types and constants of the genetic-operator block
`timescale 1ns / 1ps

package gabcm_pkg;

   // drand48 recurrence
   localparam int          GEN_W     = 48;
   localparam int          HALF_W    = 24;
   localparam int          MULT_W    = 35;
   localparam logic [34:0] LCG_MULT  = 35'h5_DEEC_E66D;
   localparam logic [47:0] LCG_INC   = 48'hB;
   localparam logic [15:0] SEED_LOW  = 16'h330E;
   localparam int          SEED_W    = 32;
   localparam int          THR_W     = 49;
   localparam int          BYTE_W    = 8;
   localparam int          CNT_W     = 3;
   localparam logic [2:0]  LAST_DRAW = 3'd7;

   // Register map
   localparam int          CSR_ADDR_W = 5;
   localparam int          CSR_DATA_W = 64;
   localparam logic [1:0]  REG_MUT    = 2'd0;
   localparam logic [1:0]  REG_XO     = 2'd1;
   localparam logic [1:0]  REG_SEED   = 2'd2;

   // Operation codes
   localparam logic        OP_MUTATE    = 1'b0;
   localparam logic        OP_CROSSOVER = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LO,
      ST_HI,
      ST_TEST,
      ST_DONE
   } ctrl_state_type;

   // Sequencer commands to the generator
   typedef struct packed {
      logic step_lo;
      logic step_hi;
   } lcg_cmd_type;

   // Seed reload from the register block
   typedef struct packed {
      logic              load;
      logic [31:0]       seed;
   } seed_cmd_type;

endpackage

// File: rtl/core/gabcm_csr.sv
// Configuration registers behind the APB-style port
`timescale 1ns / 1ps

module gabcm_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [gabcm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [gabcm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [gabcm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready,
   output logic [gabcm_pkg::THR_W-1:0]           mut_thr,
   output logic [gabcm_pkg::THR_W-1:0]           xo_thr,
   output gabcm_pkg::seed_cmd_type               seed_cmd
);

   logic [gabcm_pkg::THR_W-1:0]  mut_thr_ff, mut_thr_in;
   logic [gabcm_pkg::THR_W-1:0]  xo_thr_ff,  xo_thr_in;
   logic [gabcm_pkg::SEED_W-1:0] seed_ff,    seed_in;
   logic                         wr_en;
   logic [1:0]                   reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[4:3];

   // Write decode
   always_comb begin
      mut_thr_in    = mut_thr_ff;
      xo_thr_in     = xo_thr_ff;
      seed_in       = seed_ff;
      seed_cmd.load = 1'b0;
      if (wr_en) begin
         unique case (reg_idx)
            gabcm_pkg::REG_MUT:  mut_thr_in = csr_pwdata[gabcm_pkg::THR_W-1:0];
            gabcm_pkg::REG_XO:   xo_thr_in  = csr_pwdata[gabcm_pkg::THR_W-1:0];
            gabcm_pkg::REG_SEED: begin
               seed_in       = csr_pwdata[gabcm_pkg::SEED_W-1:0];
               seed_cmd.load = 1'b1;
            end
            default: ;
         endcase
      end
      seed_cmd.seed = seed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mut_thr_ff <= '0;
         xo_thr_ff  <= '0;
         seed_ff    <= '0;
      end else begin
         mut_thr_ff <= mut_thr_in;
         xo_thr_ff  <= xo_thr_in;
         seed_ff    <= seed_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_idx)
         gabcm_pkg::REG_MUT:  csr_prdata = {15'b0, mut_thr_ff};
         gabcm_pkg::REG_XO:   csr_prdata = {15'b0, xo_thr_ff};
         gabcm_pkg::REG_SEED: csr_prdata = {32'b0, seed_ff};
         default:             csr_prdata = '0;
      endcase
   end

   assign mut_thr = mut_thr_ff;
   assign xo_thr  = xo_thr_ff;

endmodule

// File: rtl/core/gabcm_lcg.sv
// 48-bit generator with one shared 24x35 multiplier, two passes per step
`timescale 1ns / 1ps

module gabcm_lcg (
   input  logic                             clock,
   input  logic                             reset,
   input  gabcm_pkg::lcg_cmd_type           cmd,
   input  gabcm_pkg::seed_cmd_type          seed_cmd,
   output logic [gabcm_pkg::GEN_W-1:0]      gen_state
);

   localparam int PROD_W = gabcm_pkg::HALF_W + gabcm_pkg::MULT_W;

   logic [gabcm_pkg::GEN_W-1:0]  state_ff, state_in;
   logic [gabcm_pkg::GEN_W-1:0]  part_ff,  part_in;
   logic [gabcm_pkg::HALF_W-1:0] mul_x;
   logic [PROD_W-1:0]            mul_p;

   // Low pass takes x[23:0], high pass x[47:24]
   assign mul_x = cmd.step_hi ? state_ff[gabcm_pkg::GEN_W-1:gabcm_pkg::HALF_W]
                              : state_ff[gabcm_pkg::HALF_W-1:0];
   assign mul_p = {{gabcm_pkg::MULT_W{1'b0}}, mul_x}
                * {{gabcm_pkg::HALF_W{1'b0}}, gabcm_pkg::LCG_MULT};

   // Low pass: xl*M + c; high pass adds (xh*M mod 2^24) << 24
   always_comb begin
      part_in  = part_ff;
      state_in = state_ff;
      if (cmd.step_lo) begin
         part_in = mul_p[gabcm_pkg::GEN_W-1:0] + gabcm_pkg::LCG_INC;
      end
      if (cmd.step_hi) begin
         state_in = part_ff + {mul_p[gabcm_pkg::HALF_W-1:0], {gabcm_pkg::HALF_W{1'b0}}};
      end
      if (seed_cmd.load) begin
         state_in = {seed_cmd.seed, gabcm_pkg::SEED_LOW};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= {{gabcm_pkg::SEED_W{1'b0}}, gabcm_pkg::SEED_LOW};
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
   end

   assign gen_state = state_ff;

endmodule

// File: rtl/core/gabcm_ctrl.sv
// Sequencer: draws, mask build, bit operation and result register
`timescale 1ns / 1ps

module gabcm_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,
   output logic                            rsp_tlast,
   input  logic [gabcm_pkg::THR_W-1:0]     mut_thr,
   input  logic [gabcm_pkg::THR_W-1:0]     xo_thr,
   input  logic [gabcm_pkg::GEN_W-1:0]     gen_state,
   output gabcm_pkg::lcg_cmd_type          lcg_cmd
);

   gabcm_pkg::ctrl_state_type          state_ff, state_in;
   logic [gabcm_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [gabcm_pkg::BYTE_W-1:0]       mask_ff, mask_in;
   logic                               op_ff, op_in;
   logic [gabcm_pkg::BYTE_W-1:0]       a_ff, a_in, b_ff, b_in;
   logic                               last_ff, last_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [15:0]                        rsp_data_ff, rsp_data_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic [gabcm_pkg::THR_W-1:0]        thr;
   logic                               hit;
   logic                               accept;
   logic                               load_out;
   logic [gabcm_pkg::BYTE_W-1:0]       swap;
   logic [gabcm_pkg::BYTE_W-1:0]       res_a, res_b;

   assign req_tready = (state_ff == gabcm_pkg::ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   // Draw versus the threshold of the current operation
   assign thr = (op_ff == gabcm_pkg::OP_CROSSOVER) ? xo_thr : mut_thr;
   assign hit = ({1'b0, gen_state} < thr);

   // Bit operation on the finished mask
   assign swap = (a_ff ^ b_ff) & ~mask_ff;
   always_comb begin
      if (op_ff == gabcm_pkg::OP_CROSSOVER) begin
         res_a = a_ff ^ swap;
         res_b = b_ff ^ swap;
      end else begin
         res_a = a_ff ^ mask_ff;
         res_b = b_ff;
      end
   end

   // Next state and datapath control
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      mask_in         = mask_ff;
      op_in           = op_ff;
      a_in            = a_ff;
      b_in            = b_ff;
      last_in         = last_ff;
      load_out        = 1'b0;
      lcg_cmd.step_lo = 1'b0;
      lcg_cmd.step_hi = 1'b0;
      unique case (state_ff)
         gabcm_pkg::ST_IDLE: begin
            if (accept) begin
               op_in    = req_tuser;
               a_in     = req_tdata[7:0];
               b_in     = req_tdata[15:8];
               last_in  = req_tlast;
               cnt_in   = '0;
               state_in = gabcm_pkg::ST_LO;
            end
         end
         gabcm_pkg::ST_LO: begin
            lcg_cmd.step_lo = 1'b1;
            // previous draw is now in the generator register
            if (cnt_ff != '0) begin
               mask_in = {mask_ff[gabcm_pkg::BYTE_W-2:0], hit};
            end
            state_in = gabcm_pkg::ST_HI;
         end
         gabcm_pkg::ST_HI: begin
            lcg_cmd.step_hi = 1'b1;
            cnt_in          = cnt_ff + 1'b1;
            state_in        = (cnt_ff == gabcm_pkg::LAST_DRAW) ? gabcm_pkg::ST_TEST
                                                               : gabcm_pkg::ST_LO;
         end
         gabcm_pkg::ST_TEST: begin
            mask_in  = {mask_ff[gabcm_pkg::BYTE_W-2:0], hit};
            state_in = gabcm_pkg::ST_DONE;
         end
         gabcm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_out = 1'b1;
               state_in = gabcm_pkg::ST_IDLE;
            end
         end
         default: state_in = gabcm_pkg::ST_IDLE;
      endcase
   end

   // Result register
   assign rsp_valid_in = load_out | (rsp_valid_ff & ~rsp_tready);
   assign rsp_data_in  = load_out ? {res_b, res_a} : rsp_data_ff;
   assign rsp_last_in  = load_out ? last_ff : rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gabcm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      mask_ff     <= mask_in;
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: rtl/core/ga_bitwise_crossover_mutation_top.sv
// Top level of the bitwise crossover / mutation unit
//
//  channel  | direction | carries
//  ---------+-----------+-----------------------------------------------
//  req_     | in        | tdata byte_a, byte_b; tuser op; tlast last_byte
//  rsp_     | out       | tdata out_a, out_b; tlast last_out
//  csr_     | in/out    | thresholds (8*i) and seed, 64-bit data
//
//  An item occupies the block from its transfer to the next possible input
//  transfer: eight generator steps of two passes each through the shared
//  24x35 multiplier, a compare state, a result state and the idle state
//  that takes the next transfer.
//  The result waits in its own register, so a stalled rsp_ side only holds
//  the block once a second result is ready. Reset is synchronous and puts
//  the generator at seed zero.
`timescale 1ns / 1ps

module ga_bitwise_crossover_mutation_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // byte_a, byte_b
   input  logic                              req_tuser,  // op
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,  // out_a, out_b
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gabcm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [gabcm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [gabcm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);

`include "ga_bitwise_crossover_mutation_top_macros.svh"

   logic [gabcm_pkg::THR_W-1:0]  mut_thr;
   logic [gabcm_pkg::THR_W-1:0]  xo_thr;
   logic [gabcm_pkg::GEN_W-1:0]  gen_state;
   gabcm_pkg::seed_cmd_type      seed_cmd;
   gabcm_pkg::lcg_cmd_type       lcg_cmd;

   gabcm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mut_thr     (mut_thr),
      .xo_thr      (xo_thr),
      .seed_cmd    (seed_cmd)
   );

   gabcm_lcg u_lcg (
      .clock     (clock),
      .reset     (reset),
      .cmd       (lcg_cmd),
      .seed_cmd  (seed_cmd),
      .gen_state (gen_state)
   );

   gabcm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .mut_thr    (mut_thr),
      .xo_thr     (xo_thr),
      .gen_state  (gen_state),
      .lcg_cmd    (lcg_cmd)
   );

   // Checks
   `GABCM_ASSERT(a_busy_after_take, req_tvalid && req_tready |=> !req_tready, "accepted while busy")
   `GABCM_ASSERT(a_gen_moves_on_cmd, !lcg_cmd.step_hi && !seed_cmd.load |=> $stable(gen_state), "generator moved without a step")
   `GABCM_ASSERT(a_result_from_work, $rose(rsp_tvalid) |-> !$past(req_tready), "result without work")
   `GABCM_ASSERT_ALWAYS(a_one_pass, !(lcg_cmd.step_lo && lcg_cmd.step_hi), "both multiplier passes at once")

endmodule
